### sv/mcas_pkg.sv
package mcas_pkg;
	localparam int MAX_SIZE_DEF  = 16;
	localparam int COST_BITS_DEF = 32;
	localparam int POT_W         = 40;
	localparam logic signed [POT_W-1:0] POT_MAX = {1'b0, {(POT_W-1){1'b1}}};
	localparam logic signed [POT_W-1:0] POT_MIN = {1'b1, {(POT_W-1){1'b0}}};
	localparam int SIZE_W        = 5;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	typedef enum logic [3:0] {
		ST_LOAD, ST_INIT, ST_ROW, ST_SCAN_RD, ST_SCAN, ST_UPD,
		ST_AUG, ST_COLLECT, ST_EMIT
	} state_t;

	// saturating add onto the 40-bit range
	function automatic logic signed [POT_W-1:0] sat_add(
		input logic signed [POT_W-1:0] a, input logic signed [POT_W-1:0] b);
		logic signed [POT_W:0] s;
		s = {a[POT_W-1], a} + {b[POT_W-1], b};
		if (s > $signed({1'b0, POT_MAX})) return POT_MAX;
		else if (s < $signed({1'b1, POT_MIN})) return POT_MIN;
		else return s[POT_W-1:0];
	endfunction

	function automatic logic signed [POT_W-1:0] sat_sub(
		input logic signed [POT_W-1:0] a, input logic signed [POT_W-1:0] b);
		logic signed [POT_W:0] s;
		s = {a[POT_W-1], a} - {b[POT_W-1], b};
		if (s > $signed({1'b0, POT_MAX})) return POT_MAX;
		else if (s < $signed({1'b1, POT_MIN})) return POT_MIN;
		else return s[POT_W-1:0];
	endfunction
endpackage

### sv/min_cost_assignment_solver_unit.sv
// channel   | dir | payload
// s_axis    | in  | tdata[31:0] cost_value
// m_axis    | out | tdata[7:0] {assigned_column, row_index}, tlast last_row
// cfg       | in  | matrix_size, written when cfg_we is high
// costs load one per cycle into a cost memory with separate write and read ports;
// after the last one the solve runs on the potentials, slack and link arrays, one
// column at a time, with each row repeating a scan and an update before it augments.
// results then leave one per cycle while m_axis_tready is high; no input is taken
// from the last cost until the last result has gone. reset (arst_n) clears control
// state only; the cost memory is undefined until written.
module min_cost_assignment_solver_unit #(
	parameter int MAX_SIZE  = mcas_pkg::MAX_SIZE_DEF,
	parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                  cfg_we,
	input  logic [4:0]            cfg_wdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [((COST_BITS+7)/8)*8-1:0] s_axis_tdata, // cost_value
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata, // assigned_column, row_index
	output logic                  m_axis_tlast  // last_row
);
	localparam int PW  = mcas_pkg::POT_W;
	localparam int IW  = $clog2(MAX_SIZE + 1);
	localparam int AW  = $clog2(MAX_SIZE * MAX_SIZE);
	localparam int CW  = $clog2(MAX_SIZE * MAX_SIZE + 1);
	localparam int GW  = IW + 1;
	typedef logic signed [PW-1:0] pot_t;

	logic [4:0] size_q;
	logic [IW-1:0] n;
	always_comb begin
		if (size_q == 5'd0) n = IW'(1);
		else if (32'(size_q) > MAX_SIZE) n = IW'(MAX_SIZE);
		else n = IW'(size_q);
	end

	logic signed [COST_BITS-1:0] cost_mem [MAX_SIZE*MAX_SIZE];
	logic signed [COST_BITS-1:0] cost_rd_q;
	logic [AW-1:0] mem_raddr;
	logic [CW-1:0] load_q;

	pot_t u_q [MAX_SIZE+1];
	pot_t v_q [MAX_SIZE+1];
	pot_t minv_q [MAX_SIZE+1];
	logic [IW-1:0] p_q [MAX_SIZE+1];
	logic [IW-1:0] way_q [MAX_SIZE+1];
	logic [MAX_SIZE:0] used_q;

	mcas_pkg::state_t state_q, state_d;
	logic [IW-1:0] i_q, j0_q, j1_q, j_q, i0_q;
	logic [GW-1:0] guard_q;
	pot_t delta_q;
	logic [3:0] col_q [MAX_SIZE+1];

	wire s_fire = s_axis_tvalid && s_axis_tready;
	wire [CW-1:0] total = CW'(n) * CW'(n);
	assign s_axis_tready = (state_q == mcas_pkg::ST_LOAD);

	// cost memory, row-major, with a registered read
	always_ff @(posedge clk) begin
		if (s_fire) cost_mem[load_q[AW-1:0]] <= s_axis_tdata[COST_BITS-1:0];
		cost_rd_q <= cost_mem[mem_raddr];
	end
	logic [IW-1:0] i0_eff;
	assign i0_eff = (i0_q < IW'(1) || i0_q > n) ? IW'(1) : i0_q;
	assign mem_raddr = AW'((32'(i0_eff) - 1) * 32'(n) + 32'(j_q) - 1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcas_pkg::ST_LOAD:    if (s_fire && load_q + CW'(1) >= total) state_d = mcas_pkg::ST_INIT;
			mcas_pkg::ST_INIT:    state_d = mcas_pkg::ST_ROW;
			mcas_pkg::ST_ROW:     state_d = mcas_pkg::ST_SCAN_RD;
			mcas_pkg::ST_SCAN_RD: state_d = mcas_pkg::ST_SCAN;
			mcas_pkg::ST_SCAN:    if (j_q == n) state_d = mcas_pkg::ST_UPD;
			                      else state_d = mcas_pkg::ST_SCAN_RD;
			mcas_pkg::ST_UPD:     if (j_q == n) begin
				if (j1_q != '0 && p_q[j1_q] != '0 && guard_q + GW'(1) <= GW'(n))
					state_d = mcas_pkg::ST_SCAN_RD;
				else state_d = mcas_pkg::ST_AUG;
			end
			mcas_pkg::ST_AUG:     if (j0_q == '0 || guard_q > GW'(n)) begin
				if (i_q == n) state_d = mcas_pkg::ST_COLLECT;
				else state_d = mcas_pkg::ST_ROW;
			end
			mcas_pkg::ST_COLLECT: if (j_q == n) state_d = mcas_pkg::ST_EMIT;
			mcas_pkg::ST_EMIT:    if (m_axis_tready && i_q + IW'(1) == n) state_d = mcas_pkg::ST_LOAD;
			default:              state_d = mcas_pkg::ST_LOAD;
		endcase
	end

	pot_t cur;
	pot_t slk;
	always_comb begin
		cur = mcas_pkg::sat_sub(mcas_pkg::sat_sub(PW'(cost_rd_q), u_q[i0_eff]), v_q[j_q]);
		slk = (cur < minv_q[j_q]) ? cur : minv_q[j_q];
	end

	logic [IW-1:0] lnk;
	assign lnk = (way_q[j0_q] > n) ? '0 : way_q[j0_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcas_pkg::ST_LOAD;
			size_q  <= mcas_pkg::SIZE_RESET;
			load_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				size_q <= cfg_wdata;
				load_q <= '0;
			end else if (s_fire) begin
				if (load_q + CW'(1) >= total) load_q <= '0;
				else load_q <= load_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mcas_pkg::ST_INIT: begin
				for (int k = 0; k <= MAX_SIZE; k++) begin
					u_q[k] <= '0; v_q[k] <= '0; p_q[k] <= '0; way_q[k] <= '0;
				end
				i_q <= '0;
			end
			mcas_pkg::ST_ROW: begin
				i_q <= i_q + IW'(1);
				p_q[0] <= i_q + IW'(1);
				i0_q <= i_q + IW'(1);
				for (int k = 0; k <= MAX_SIZE; k++) minv_q[k] <= mcas_pkg::POT_MAX;
				// only the virtual column starts visited
				used_q <= (MAX_SIZE+1)'(1);
				j0_q <= '0; j1_q <= '0; j_q <= IW'(1);
				delta_q <= mcas_pkg::POT_MAX; guard_q <= '0;
			end
			mcas_pkg::ST_SCAN: begin
				if (!used_q[j_q]) begin
					if (cur < minv_q[j_q]) begin
						minv_q[j_q] <= cur;
						way_q[j_q] <= j0_q;
					end
					if (slk < delta_q) begin
						delta_q <= slk; j1_q <= j_q;
					end else if (j1_q == '0) j1_q <= j_q;
				end
				if (j_q == n) j_q <= '0;
				else j_q <= j_q + IW'(1);
			end
			mcas_pkg::ST_UPD: begin
				if (used_q[j_q]) begin
					if (p_q[j_q] <= n)
						u_q[p_q[j_q]] <= mcas_pkg::sat_add(u_q[p_q[j_q]], delta_q);
					v_q[j_q] <= mcas_pkg::sat_sub(v_q[j_q], delta_q);
				end else
					minv_q[j_q] <= mcas_pkg::sat_sub(minv_q[j_q], delta_q);
				if (j_q == n) begin
					j0_q <= j1_q;
					used_q[j1_q] <= 1'b1;
					i0_q <= p_q[j1_q];
					j1_q <= '0; j_q <= IW'(1);
					delta_q <= mcas_pkg::POT_MAX;
					if (j1_q != '0 && p_q[j1_q] != '0 && guard_q + GW'(1) <= GW'(n))
						guard_q <= guard_q + GW'(1);
					else guard_q <= '0;
				end else j_q <= j_q + IW'(1);
			end
			mcas_pkg::ST_AUG: begin
				if (j0_q != '0 && guard_q <= GW'(n)) begin
					p_q[j0_q] <= p_q[lnk];
					j0_q <= lnk;
					guard_q <= guard_q + GW'(1);
				end else j_q <= IW'(1);
				if (j0_q == '0 || guard_q > GW'(n)) begin
					for (int k = 0; k <= MAX_SIZE; k++) col_q[k] <= '0;
				end
			end
			mcas_pkg::ST_COLLECT: begin
				if (p_q[j_q] >= IW'(1) && p_q[j_q] <= n) col_q[p_q[j_q]] <= 4'(j_q - IW'(1));
				if (j_q == n) i_q <= '0;
				else j_q <= j_q + IW'(1);
			end
			mcas_pkg::ST_EMIT: if (m_axis_tready) i_q <= i_q + IW'(1);
			default: ;
		endcase
	end

	assign m_axis_tvalid = (state_q == mcas_pkg::ST_EMIT);
	assign m_axis_tdata  = {col_q[i_q + IW'(1)], 4'(i_q)};
	assign m_axis_tlast  = (i_q + IW'(1) == n);

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in and out overlap");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("no return to load");
	a_load_bound: assert property (@(posedge clk) disable iff (!arst_n)
		load_q < total || cfg_we || $past(cfg_we)) else $error("load count overrun");
endmodule
